FILE: src/gds_pkg.sv
// Shared types, codes and helper functions for the Gregorian date stepper.
// Holds the micro-program ROM used by gds_sequencer; no dependencies.
`default_nettype none

package gds_pkg;

   // request codes
   localparam logic [1:0] REQ_SET     = 2'd0;
   localparam logic [1:0] REQ_ADD     = 2'd1;
   localparam logic [1:0] REQ_SUNDAY  = 2'd2;
   localparam logic [1:0] REQ_WEEKDAY = 2'd3;

   // datapath operations
   localparam logic [3:0] OP_NOP     = 4'd0;
   localparam logic [3:0] OP_LOAD    = 4'd1;
   localparam logic [3:0] OP_SETLOAD = 4'd2;
   localparam logic [3:0] OP_Q100    = 4'd3;
   localparam logic [3:0] OP_LEAP    = 4'd4;
   localparam logic [3:0] OP_SETFIX  = 4'd5;
   localparam logic [3:0] OP_WDSTART = 4'd6;
   localparam logic [3:0] OP_SETN    = 4'd7;
   localparam logic [3:0] OP_STEP    = 4'd8;
   localparam logic [3:0] OP_RESTORE = 4'd9;
   localparam logic [3:0] OP_COMMIT  = 4'd10;
   localparam logic [3:0] OP_OUTPUT  = 4'd11;

   // jump kinds
   localparam logic [2:0] J_NEXT     = 3'd0;
   localparam logic [2:0] J_GOTO     = 3'd1;
   localparam logic [2:0] J_IF_BAD   = 3'd2;
   localparam logic [2:0] J_WAIT_WD  = 3'd3;
   localparam logic [2:0] J_WAIT_OUT = 3'd4;
   localparam logic [2:0] J_DISPATCH = 3'd5;
   localparam logic [2:0] J_LOOP     = 3'd6;

   // program addresses
   localparam logic [3:0] P_IDLE  = 4'd0;
   localparam logic [3:0] P_SET   = 4'd1;
   localparam logic [3:0] P_SETQ  = 4'd2;
   localparam logic [3:0] P_SETL  = 4'd3;
   localparam logic [3:0] P_SETF  = 4'd4;
   localparam logic [3:0] P_NWD   = 4'd5;
   localparam logic [3:0] P_NWAIT = 4'd6;
   localparam logic [3:0] P_NSETN = 4'd7;
   localparam logic [3:0] P_LOOP  = 4'd8;
   localparam logic [3:0] P_LQ    = 4'd9;
   localparam logic [3:0] P_LL    = 4'd10;
   localparam logic [3:0] P_ERR   = 4'd11;
   localparam logic [3:0] P_FIN   = 4'd12;
   localparam logic [3:0] P_WD    = 4'd13;
   localparam logic [3:0] P_WWAIT = 4'd14;
   localparam logic [3:0] P_OUT   = 4'd15;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] jmp;
      logic [3:0] target;
   } gds_uword_type;

   typedef struct packed {
      logic [3:0] op;
      logic       idle;
   } gds_ctrl_type;

   typedef struct packed {
      logic       req_valid;
      logic [1:0] req_type;
      logic       n_zero;
      logic       wrap;
      logic       yr_bad;
      logic       wd_done;
      logic       out_busy;
   } gds_status_type;

   function automatic gds_uword_type ucode_rom(input logic [3:0] pc);
      gds_uword_type w;
      case (pc)
         P_IDLE:  w = '{OP_LOAD,    J_DISPATCH, P_IDLE};
         P_SET:   w = '{OP_SETLOAD, J_NEXT,     P_IDLE};
         P_SETQ:  w = '{OP_Q100,    J_IF_BAD,   P_ERR};
         P_SETL:  w = '{OP_LEAP,    J_NEXT,     P_IDLE};
         P_SETF:  w = '{OP_SETFIX,  J_GOTO,     P_FIN};
         P_NWD:   w = '{OP_WDSTART, J_NEXT,     P_IDLE};
         P_NWAIT: w = '{OP_NOP,     J_WAIT_WD,  P_IDLE};
         P_NSETN: w = '{OP_SETN,    J_NEXT,     P_IDLE};
         P_LOOP:  w = '{OP_STEP,    J_LOOP,     P_FIN};
         P_LQ:    w = '{OP_Q100,    J_IF_BAD,   P_ERR};
         P_LL:    w = '{OP_LEAP,    J_GOTO,     P_LOOP};
         P_ERR:   w = '{OP_RESTORE, J_GOTO,     P_WD};
         P_FIN:   w = '{OP_COMMIT,  J_NEXT,     P_IDLE};
         P_WD:    w = '{OP_WDSTART, J_NEXT,     P_IDLE};
         P_WWAIT: w = '{OP_NOP,     J_WAIT_WD,  P_IDLE};
         P_OUT:   w = '{OP_OUTPUT,  J_WAIT_OUT, P_IDLE};
         default: w = '{OP_NOP,     J_GOTO,     P_IDLE};
      endcase
      return w;
   endfunction

   // y / 100 by reciprocal, exact for y below 16384
   function automatic logic [7:0] div100(input logic [13:0] y);
      logic [26:0] prod;
      prod = 27'(y) * 27'd5243;
      return prod[26:19];
   endfunction

   function automatic logic leap_from(input logic [13:0] y, input logic [7:0] q);
      logic cent;
      cent = (y == 14'(14'(q) * 14'd100));
      return (y[1:0] == 2'd0) && (!cent || (q[1:0] == 2'd0));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [4:0] month_doom(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      case (m)
         4'd1:    d = 5'd24 + 5'(leap);
         4'd2:    d = 5'd28 + 5'(leap);
         4'd3:    d = 5'd7;
         4'd4:    d = 5'd4;
         4'd5:    d = 5'd9;
         4'd6:    d = 5'd6;
         4'd7:    d = 5'd11;
         4'd8:    d = 5'd8;
         4'd9:    d = 5'd5;
         4'd10:   d = 5'd10;
         4'd11:   d = 5'd7;
         default: d = 5'd12;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: src/gds_weekday.sv
// Four-stage Doomsday weekday unit: date in, weekday (0 Sunday) out.
// Depends on gds_pkg for the doomsday table and the divide-by-100 helper.
`default_nettype none

module gds_weekday
   import gds_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [4:0]  day,
   input  wire logic [3:0]  month,
   input  wire logic [13:0] year,
   input  wire logic        leap,
   output logic             done,
   output logic [2:0]       weekday
);

   logic [3:0]  vld_ff, vld_in;
   logic [7:0]  q1_ff, q1_in, q2_ff, q2_in;
   logic [13:0] y1_ff, y1_in;
   logic [6:0]  base1_ff, base1_in, base2_ff, base2_in;
   logic [6:0]  ldy2_ff, ldy2_in;
   logic [9:0]  t3_ff, t3_in;
   logic [2:0]  wd_ff, wd_in;

   logic [12:0] a_prod;
   logic [3:0]  a_q, r12;
   logic [21:0] m_prod;
   logic [7:0]  q7;

   always_comb begin
      vld_in   = {vld_ff[2:0], start};
      // stage 1: century quotient and day minus doomsday, offset to stay positive
      q1_in    = div100(year);
      y1_in    = year;
      base1_in = 7'(day) + 7'd39 - 7'(month_doom(month, leap));
      // stage 2: year within the century
      ldy2_in  = 7'(y1_ff - 14'(14'(q1_ff) * 14'd100));
      q2_in    = q1_ff;
      base2_in = base1_ff;
      // stage 3: anchor terms, all folded into one sum taken mod 7 later
      a_prod   = 13'(ldy2_ff) * 13'd43;
      a_q      = a_prod[12:9];
      r12      = 4'(ldy2_ff - 7'(7'(a_q) * 7'd12));
      t3_in    = 10'(base2_ff) + 10'(a_q) + 10'(r12) + 10'(r12[3:2])
               + 10'(10'(q2_ff) * 10'd5) + 10'd5 + 10'(q2_ff[7:2]);
      // stage 4: mod 7 by reciprocal
      m_prod   = 22'(t3_ff) * 22'd2341;
      q7       = m_prod[21:14];
      wd_in    = 3'(t3_ff - 10'(10'(q7) * 10'd7));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      q1_ff    <= q1_in;
      y1_ff    <= y1_in;
      base1_ff <= base1_in;
      ldy2_ff  <= ldy2_in;
      q2_ff    <= q2_in;
      base2_ff <= base2_in;
      t3_ff    <= t3_in;
      if (vld_ff[2]) begin
         wd_ff <= wd_in;
      end
   end

   assign done    = vld_ff[3];
   assign weekday = wd_ff;

endmodule

`default_nettype wire

FILE: src/gds_sequencer.sv
// Micro-program sequencer: step counter, control ROM fetch and jump logic.
// Depends on gds_pkg for the ROM, the jump kinds and the status/control structs.
`default_nettype none

module gds_sequencer
   import gds_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire gds_status_type status,
   output gds_ctrl_type        ctrl
);

   logic [3:0]    pc_ff, pc_in;
   gds_uword_type word;

   assign word = ucode_rom(pc_ff);

   always_comb begin
      pc_in = 4'(pc_ff + 4'd1);
      case (word.jmp)
         J_NEXT:     pc_in = 4'(pc_ff + 4'd1);
         J_GOTO:     pc_in = word.target;
         J_IF_BAD:   pc_in = status.yr_bad ? word.target : 4'(pc_ff + 4'd1);
         J_WAIT_WD:  pc_in = status.wd_done ? 4'(pc_ff + 4'd1) : pc_ff;
         J_WAIT_OUT: pc_in = status.out_busy ? pc_ff : word.target;
         J_DISPATCH: begin
            if (!status.req_valid) begin
               pc_in = pc_ff;
            end else begin
               case (status.req_type)
                  REQ_SET: pc_in = P_SET;
                  REQ_ADD: pc_in = P_LOOP;
                  default: pc_in = P_NWD;
               endcase
            end
         end
         J_LOOP: begin
            // leave when the count is used up; take the leap steps on a year change
            if (status.n_zero) begin
               pc_in = word.target;
            end else if (status.wrap) begin
               pc_in = 4'(pc_ff + 4'd1);
            end else begin
               pc_in = pc_ff;
            end
         end
         default:    pc_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= P_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op   = word.op;
   assign ctrl.idle = (pc_ff == P_IDLE);

endmodule

`default_nettype wire

FILE: src/gregorian_date_stepper.sv
// Gregorian date stepper: microcoded datapath walking month by month.
// Set loads and checks a date; next Sunday, next weekday and add walk the step loop month by month,
// taking the leap steps at each year boundary crossed.
// One item at a time; a waiting result stalls only the next output step.
// Synchronous reset: stored date 1 January 2000 (leap), sequencer idle, no result pending.
`default_nettype none

module gregorian_date_stepper
   import gds_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_type,
   input  wire logic [4:0]         req_set_day,
   input  wire logic [3:0]         req_set_month,
   input  wire logic [13:0]        req_set_year,
   input  wire logic signed [15:0] req_day_delta,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [4:0]              rsp_out_day,
   output logic [3:0]              rsp_out_month,
   output logic [13:0]             rsp_out_year,
   output logic [2:0]              rsp_weekday,
   output logic                    rsp_input_fixed,
   output logic                    rsp_range_error
);

   gds_ctrl_type   ctrl;
   gds_status_type status;

   logic               wd_done;
   logic [2:0]         wd_value;

   // working date and step count
   logic [5:0]         day_ff, day_in;
   logic [3:0]         mon_ff, mon_in;
   logic [13:0]        yr_ff, yr_in;
   logic               leap_ff, leap_in;
   logic signed [15:0] n_ff, n_in;
   logic [7:0]         q100_ff, q100_in;
   logic [1:0]         type_ff, type_in;
   logic               fixed_ff, fixed_in, err_ff, err_in;
   logic [4:0]         sd_ff, sd_in;
   logic [3:0]         sm_ff, sm_in;
   logic [13:0]        sy_ff, sy_in;

   // stored date
   logic [4:0]         cur_day_ff, cur_day_in;
   logic [3:0]         cur_month_ff, cur_month_in;
   logic [13:0]        cur_year_ff, cur_year_in;
   logic               cur_leap_ff, cur_leap_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [4:0]         rsp_day_ff, rsp_day_in;
   logic [3:0]         rsp_month_ff, rsp_month_in;
   logic [13:0]        rsp_year_ff, rsp_year_in;
   logic [2:0]         rsp_wd_ff, rsp_wd_in;
   logic               rsp_fixed_ff, rsp_fixed_in, rsp_err_ff, rsp_err_in;

   logic               out_busy;
   logic [4:0]         mx;
   logic signed [17:0] room_s, n_s, day_s;
   logic               n_pos, n_neg, pos_fits, neg_fits;
   logic [3:0]         mon_back;
   logic [3:0]         sm_fix;
   logic               bad_m, bad_d;

   assign out_busy = rsp_valid_ff & ~rsp_ready;

   assign mx       = month_len(mon_ff, leap_ff);
   assign n_s      = {{2{n_ff[15]}}, n_ff};
   assign day_s    = $signed({12'd0, day_ff});
   assign room_s   = $signed({13'd0, mx}) - day_s;
   assign n_neg    = n_ff[15];
   assign n_pos    = !n_ff[15] && (n_ff != 16'sd0);
   assign pos_fits = (room_s >= n_s);
   assign neg_fits = ((day_s + n_s) > 18'sd0);
   assign mon_back = (mon_ff == 4'd1) ? 4'd12 : 4'(mon_ff - 4'd1);

   assign bad_m    = (sm_ff == 4'd0) || (sm_ff > 4'd12);
   assign sm_fix   = bad_m ? 4'd1 : sm_ff;
   assign bad_d    = (sd_ff == 5'd0) || (sd_ff > month_len(sm_fix, leap_ff));

   assign status.req_valid = req_valid;
   assign status.req_type  = req_type;
   assign status.n_zero    = (n_ff == 16'sd0);
   assign status.wrap      = (n_pos && !pos_fits && (mon_ff == 4'd12))
                           || (n_neg && !neg_fits && (mon_ff == 4'd1));
   assign status.yr_bad    = (yr_ff == 14'd0) || (yr_ff > 14'd9999);
   assign status.wd_done   = wd_done;
   assign status.out_busy  = out_busy;

   gds_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   gds_weekday u_wd (
      .clock   (clock),
      .reset   (reset),
      .start   (ctrl.op == OP_WDSTART),
      .day     (day_ff[4:0]),
      .month   (mon_ff),
      .year    (yr_ff),
      .leap    (leap_ff),
      .done    (wd_done),
      .weekday (wd_value)
   );

   always_comb begin
      day_in       = day_ff;
      mon_in       = mon_ff;
      yr_in        = yr_ff;
      leap_in      = leap_ff;
      n_in         = n_ff;
      q100_in      = q100_ff;
      type_in      = type_ff;
      fixed_in     = fixed_ff;
      err_in       = err_ff;
      sd_in        = sd_ff;
      sm_in        = sm_ff;
      sy_in        = sy_ff;
      cur_day_in   = cur_day_ff;
      cur_month_in = cur_month_ff;
      cur_year_in  = cur_year_ff;
      cur_leap_in  = cur_leap_ff;
      rsp_day_in   = rsp_day_ff;
      rsp_month_in = rsp_month_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_wd_in    = rsp_wd_ff;
      rsp_fixed_in = rsp_fixed_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      case (ctrl.op)
         OP_LOAD: begin
            if (req_valid) begin
               day_in   = {1'b0, cur_day_ff};
               mon_in   = cur_month_ff;
               yr_in    = cur_year_ff;
               leap_in  = cur_leap_ff;
               n_in     = req_day_delta;
               type_in  = req_type;
               sd_in    = req_set_day;
               sm_in    = req_set_month;
               sy_in    = req_set_year;
               fixed_in = 1'b0;
               err_in   = 1'b0;
            end
         end
         OP_SETLOAD: yr_in   = sy_ff;
         OP_Q100:    q100_in = div100(yr_ff);
         OP_LEAP:    leap_in = leap_from(yr_ff, q100_ff);
         OP_SETFIX: begin
            mon_in   = sm_fix;
            day_in   = bad_d ? 6'd1 : {1'b0, sd_ff};
            fixed_in = bad_m | bad_d;
         end
         OP_SETN: begin
            if (type_ff == REQ_SUNDAY) begin
               n_in = 16'sd7 - $signed({13'd0, wd_value});
            end else if (wd_value == 3'd5) begin
               n_in = 16'sd3;
            end else if (wd_value == 3'd6) begin
               n_in = 16'sd2;
            end else begin
               n_in = 16'sd1;
            end
         end
         OP_STEP: begin
            if (n_pos) begin
               if (pos_fits) begin
                  day_in = 6'(day_ff + n_ff[5:0]);
                  n_in   = 16'sd0;
               end else begin
                  // run to the end of the month and roll over
                  n_in   = n_ff - room_s[15:0];
                  day_in = 6'd0;
                  if (mon_ff == 4'd12) begin
                     mon_in = 4'd1;
                     yr_in  = 14'(yr_ff + 14'd1);
                  end else begin
                     mon_in = 4'(mon_ff + 4'd1);
                  end
               end
            end else if (n_neg) begin
               if (neg_fits) begin
                  day_in = 6'(day_ff + n_ff[5:0]);
                  n_in   = 16'sd0;
               end else begin
                  // back to the day after the previous month's last
                  mon_in = mon_back;
                  if (mon_ff == 4'd1) begin
                     yr_in = 14'(yr_ff - 14'd1);
                  end
                  n_in   = n_ff + $signed({10'd0, day_ff}) - 16'sd1;
                  day_in = 6'(month_len(mon_back, leap_ff)) + 6'd1;
               end
            end
         end
         OP_RESTORE: begin
            day_in  = {1'b0, cur_day_ff};
            mon_in  = cur_month_ff;
            yr_in   = cur_year_ff;
            leap_in = cur_leap_ff;
            err_in  = 1'b1;
         end
         OP_COMMIT: begin
            if ((type_ff == REQ_SET) || (type_ff == REQ_ADD)) begin
               cur_day_in   = day_ff[4:0];
               cur_month_in = mon_ff;
               cur_year_in  = yr_ff;
               cur_leap_in  = leap_ff;
            end
         end
         OP_OUTPUT: begin
            if (!out_busy) begin
               rsp_day_in   = day_ff[4:0];
               rsp_month_in = mon_ff;
               rsp_year_in  = yr_ff;
               rsp_wd_in    = wd_value;
               rsp_fixed_in = fixed_ff;
               rsp_err_in   = err_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_day_ff   <= 5'd1;
         cur_month_ff <= 4'd1;
         cur_year_ff  <= 14'd2000;
         cur_leap_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_day_ff   <= cur_day_in;
         cur_month_ff <= cur_month_in;
         cur_year_ff  <= cur_year_in;
         cur_leap_ff  <= cur_leap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      day_ff       <= day_in;
      mon_ff       <= mon_in;
      yr_ff        <= yr_in;
      leap_ff      <= leap_in;
      n_ff         <= n_in;
      q100_ff      <= q100_in;
      type_ff      <= type_in;
      fixed_ff     <= fixed_in;
      err_ff       <= err_in;
      sd_ff        <= sd_in;
      sm_ff        <= sm_in;
      sy_ff        <= sy_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_month_ff <= rsp_month_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_wd_ff    <= rsp_wd_in;
      rsp_fixed_ff <= rsp_fixed_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign req_ready       = ctrl.idle;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_day     = rsp_day_ff;
   assign rsp_out_month   = rsp_month_ff;
   assign rsp_out_year    = rsp_year_ff;
   assign rsp_weekday     = rsp_wd_ff;
   assign rsp_input_fixed = rsp_fixed_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

`default_nettype wire

FILE: verif/tb_gregorian_date_stepper.sv
// Self-checking testbench for gregorian_date_stepper: directed and random date requests,
// with a date predictor and scoreboard held in a small class package.
// Depends on gds_pkg for the request codes; needs nothing else beside the RTL.
`default_nettype none

package date_board_pkg;
   import gds_pkg::*;

   typedef struct packed {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [2:0]  weekday;
      logic        repaired;
      logic        range_error;
   } dated_result_type;

   class date_board;
      int day, month, year;
      dated_result_type pending_dates[$];
      int unsigned faults;

      function new();
         day = 1;
         month = 1;
         year = 2000;
         faults = 0;
      endfunction

      function bit is_leap(int y);
         return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      endfunction

      function int days_in(int m, int y);
         case (m)
            4, 6, 9, 11: return 30;
            2:           return is_leap(y) ? 29 : 28;
            default:     return 31;
         endcase
      endfunction

      // day-of-week by month offsets, Sunday is 0
      function int weekday_for(int d, int m, int y);
         int shift, yy;
         case (m)
            1: shift = 0;
            2: shift = 3;
            3: shift = 2;
            4: shift = 5;
            5: shift = 0;
            6: shift = 3;
            7: shift = 5;
            8: shift = 1;
            9: shift = 4;
            10: shift = 6;
            11: shift = 2;
            default: shift = 4;
         endcase
         yy = (m < 3) ? y - 1 : y;
         return (yy + yy / 4 - yy / 100 + yy / 400 + shift + d) % 7;
      endfunction

      // walk whole months; returns 0 once the year leaves 1..9999
      function bit shift_date(int n, inout int d, inout int m, inout int y);
         int room;
         while (n > 0) begin
            room = days_in(m, y) - d;
            if (n <= room) begin
               d += n;
               n = 0;
            end else begin
               n -= room + 1;
               d = 1;
               if (m == 12) begin
                  m = 1;
                  y++;
               end else begin
                  m++;
               end
               if (y > 9999) return 0;
            end
         end
         while (n < 0) begin
            if (d + n >= 1) begin
               d += n;
               n = 0;
            end else begin
               // land on the last day of the previous month
               n += d;
               if (m == 1) begin
                  m = 12;
                  y--;
               end else begin
                  m--;
               end
               if (y < 1) return 0;
               d = days_in(m, y);
            end
         end
         return 1;
      endfunction

      function void note_request(logic [1:0] kind, logic [4:0] set_day, logic [3:0] set_month,
                                 logic [13:0] set_year, logic signed [15:0] delta);
         int d, m, y, n, wd;
         bit repaired, bad;
         dated_result_type want;
         d = day;
         m = month;
         y = year;
         repaired = 0;
         bad = 0;
         if (kind == REQ_SET) begin
            if (set_year < 1 || set_year > 9999) begin
               bad = 1;
            end else begin
               m = int'(set_month);
               d = int'(set_day);
               y = int'(set_year);
               if (m < 1 || m > 12) begin
                  m = 1;
                  repaired = 1;
               end
               if (d < 1 || d > days_in(m, y)) begin
                  d = 1;
                  repaired = 1;
               end
               day = d;
               month = m;
               year = y;
            end
         end else begin
            wd = weekday_for(d, m, y);
            if (kind == REQ_ADD) n = int'(delta);
            else if (kind == REQ_SUNDAY) n = 7 - wd;
            else if (wd == 5) n = 3;
            else if (wd == 6) n = 2;
            else n = 1;
            if (!shift_date(n, d, m, y)) begin
               bad = 1;
               d = day;
               m = month;
               y = year;
            end else if (kind == REQ_ADD) begin
               day = d;
               month = m;
               year = y;
            end
         end
         want.day = 5'(d);
         want.month = 4'(m);
         want.year = 14'(y);
         want.weekday = 3'(weekday_for(d, m, y));
         want.repaired = repaired;
         want.range_error = bad;
         pending_dates.push_back(want);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            faults++;
         end
      endfunction

      function void check_result(dated_result_type got);
         dated_result_type want;
         if (pending_dates.size() == 0) begin
            $error("result %0d-%0d-%0d arrived with no request outstanding",
                   got.year, got.month, got.day);
            faults++;
            return;
         end
         want = pending_dates.pop_front();
         compare_field("out_day", 16'(want.day), 16'(got.day));
         compare_field("out_month", 16'(want.month), 16'(got.month));
         compare_field("out_year", 16'(want.year), 16'(got.year));
         compare_field("weekday", 16'(want.weekday), 16'(got.weekday));
         compare_field("input_fixed", 16'(want.repaired), 16'(got.repaired));
         compare_field("range_error", 16'(want.range_error), 16'(got.range_error));
      endfunction
   endclass

endpackage

module tb_gregorian_date_stepper;
   import gds_pkg::*;
   import date_board_pkg::*;

   localparam int RANDOM_ITEMS = 540;
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 64;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_type = REQ_SET;
   logic [4:0]         req_set_day = '0;
   logic [3:0]         req_set_month = '0;
   logic [13:0]        req_set_year = '0;
   logic signed [15:0] req_day_delta = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [4:0]         rsp_out_day;
   logic [3:0]         rsp_out_month;
   logic [13:0]        rsp_out_year;
   logic [2:0]         rsp_weekday;
   logic               rsp_input_fixed;
   logic               rsp_range_error;

   date_board board;
   bit calm = 1'b0;
   int unsigned hold_asks = 0;

   gregorian_date_stepper i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_set_day     (req_set_day),
      .req_set_month   (req_set_month),
      .req_set_year    (req_set_year),
      .req_day_delta   (req_day_delta),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_year    (rsp_out_year),
      .rsp_weekday     (rsp_weekday),
      .rsp_input_fixed (rsp_input_fixed),
      .rsp_range_error (rsp_range_error)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_request(req_type, req_set_day, req_set_month, req_set_year, req_day_delta);
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(dated_result_type'{rsp_out_day, rsp_out_month, rsp_out_year,
                                               rsp_weekday, rsp_input_fixed, rsp_range_error});
   end

   // result sink: random back-pressure, plus a long hold-off when asked
   initial begin
      int unsigned served;
      served = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != served) begin
            served = hold_asks;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(99) >= 38);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("gregorian_date_stepper: mismatch");
      $finish;
   end

   // present one request beat, idling first at random, and hold it until taken
   task automatic offer(input logic [1:0] kind, input logic [4:0] sd, input logic [3:0] sm,
                        input logic [13:0] sy, input logic signed [15:0] delta);
      if (!calm && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 38);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_set_day <= sd;
      req_set_month <= sm;
      req_set_year <= sy;
      req_day_delta <= delta;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int random_sent, follow, roll;
      logic [1:0] kind;
      logic [4:0] sd;
      logic [3:0] sm;
      logic [13:0] sy;
      logic signed [15:0] delta;

      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset date is a Saturday
      offer(REQ_ADD, '0, '0, '0, 16'sd0);
      offer(REQ_SUNDAY, '0, '0, '0, 16'sd0);
      offer(REQ_WEEKDAY, '0, '0, '0, 16'sd0);
      offer(REQ_SET, 5'd2, 4'd1, 14'd2000, 16'sd0);      // a Sunday
      offer(REQ_SUNDAY, '0, '0, '0, 16'sd0);
      offer(REQ_SET, 5'd29, 4'd2, 14'd2000, 16'sd0);
      offer(REQ_ADD, '0, '0, '0, 16'sd1);
      offer(REQ_SET, 5'd29, 4'd2, 14'd1900, 16'sd0);     // no 29 February in 1900, a century year not divisible by 400
      offer(REQ_SET, 5'd0, 4'd0, 14'd2024, 16'sd0);
      offer(REQ_SET, 5'd31, 4'd15, 14'd2023, 16'sd0);
      offer(REQ_SET, 5'd31, 4'd4, 14'd2023, 16'sd0);
      offer(REQ_SET, 5'd10, 4'd5, 14'd0, 16'sd0);
      offer(REQ_SET, 5'd31, 4'd15, 14'd16383, 16'sd0);
      offer(REQ_SET, 5'd1, 4'd1, 14'd10000, 16'sd0);
      offer(REQ_SET, 5'd31, 4'd12, 14'd9999, 16'sd0);    // a Friday
      offer(REQ_ADD, '0, '0, '0, 16'sd1);
      offer(REQ_WEEKDAY, '0, '0, '0, 16'sd0);
      offer(REQ_SUNDAY, '0, '0, '0, 16'sd0);
      offer(REQ_ADD, '0, '0, '0, -16'sd1);
      offer(REQ_SET, 5'd1, 4'd1, 14'd1, 16'sd0);
      offer(REQ_ADD, '0, '0, '0, -16'sd1);
      offer(REQ_ADD, '0, '0, '0, 16'sd32767);
      offer(REQ_ADD, 5'd31, 4'd15, 14'd16383, -16'sd32768);
      offer(REQ_ADD, '0, '0, '0, 16'sd32767);
      offer(REQ_SET, 5'd31, 4'd12, 14'd9990, 16'sd0);
      offer(REQ_ADD, '0, '0, '0, 16'sd32767);

      // random: mostly a set followed by a short run of steps from that date
      random_sent = 0;
      follow = 0;
      while (random_sent < RANDOM_ITEMS) begin
         calm = (random_sent >= 200) && (random_sent < 320);
         if (random_sent == 60) hold_asks++;
         if (random_sent == 400) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (board.pending_dates.size() != 0);
         end

         roll = $urandom_range(99);
         if (roll < 20) sy = 14'($urandom_range(3, 1));
         else if (roll < 40) sy = 14'($urandom_range(9999, 9990));
         else if (roll < 48) sy = 14'($urandom);
         else sy = 14'($urandom_range(9999, 1));
         sm = ($urandom_range(99) < 85) ? 4'($urandom_range(12, 1)) : 4'($urandom);
         sd = 5'($urandom);
         roll = $urandom_range(99);
         if (roll < 65) delta = 16'($urandom_range(80) - 40);
         else if (roll < 88) delta = 16'($urandom_range(3000) - 1500);
         else delta = 16'($urandom);

         if (follow == 0) begin
            follow = $urandom_range(6, 1);
            kind = ($urandom_range(99) < 92) ? REQ_SET : 2'($urandom);
         end else begin
            follow--;
            roll = $urandom_range(99);
            if (roll < 60) kind = REQ_ADD;
            else if (roll < 80) kind = REQ_SUNDAY;
            else kind = REQ_WEEKDAY;
         end
         offer(kind, sd, sm, sy, delta);
         random_sent++;
      end

      req_valid <= 1'b0;
      calm = 1'b0;
      do @(posedge clock); while (board.pending_dates.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.faults == 0)
         $display("gregorian_date_stepper: match");
      else
         $display("gregorian_date_stepper: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
src/gds_pkg.sv
src/gds_weekday.sv
src/gds_sequencer.sv
src/gregorian_date_stepper.sv
verif/tb_gregorian_date_stepper.sv
